// ===== rtl/txbf_pkg.sv =====
`timescale 1ns / 1ps

package txbf_pkg;

  // Default ring size and the marker value that reset loads.
  localparam int unsigned DEPTH_DEF = 64;
  localparam logic [7:0] MARKER_RESET = 8'd88;

  // Action codes of an input item.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_MARKED    = 3'd1,
    ST_DISCARDED = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

// ===== rtl/txbf_ring.sv =====
`timescale 1ns / 1ps

module txbf_ring #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                action,
  input  logic [7:0]          data_byte,
  input  logic                end_of_message,
  input  logic [7:0]          marker,
  output txbf_pkg::status_t   status,
  output logic [7:0]          rd_data
);

  import txbf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          discard_r, discard_nxt;
  logic [AW-1:0] wr_next, wr_prev, rd_next;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [7:0]    rd_data_r;

  assign wr_next = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign wr_prev = (wr_idx_r == '0) ? LAST_IDX : wr_idx_r - 1'b1;
  assign rd_next = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    discard_nxt = discard_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_idx_r;
    mem_wdata   = data_byte;
    mem_re      = 1'b0;
    status      = ST_EMPTY;
    case (action)
      ACT_PUSH: begin
        if (discard_r) begin
          status = ST_DISCARDED;
          if (end_of_message) begin
            discard_nxt = 1'b0;
          end
        end else if (wr_next == rd_idx_r) begin
          // Ring full: overwrite the newest byte with the marker.
          status      = ST_MARKED;
          mem_we      = 1'b1;
          mem_waddr   = wr_prev;
          mem_wdata   = marker;
          discard_nxt = !end_of_message;
        end else begin
          status     = ST_STORED;
          mem_we     = 1'b1;
          wr_idx_nxt = wr_next;
        end
      end
      ACT_POP: begin
        if (wr_idx_r == rd_idx_r) begin
          status = ST_EMPTY;
        end else begin
          status     = ST_POPPED;
          mem_re     = 1'b1;
          rd_idx_nxt = rd_next;
        end
      end
      default: begin
        status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      discard_r <= 1'b0;
    end else if (en) begin
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read data is held until the next accepted pop.
  always_ff @(posedge clk) begin
    if (en && mem_re) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tx_byte_fifo_overflow_marking.sv =====
`timescale 1ns / 1ps

// Transmit byte ring buffer with overflow marking.
// The input channel (in_valid/in_ready) carries one item per push or pop:
// in_action selects push or pop, in_data_byte and in_end_of_message describe
// the pushed byte. The ring holds DEPTH-1 bytes. A push into a full ring
// overwrites the newest stored byte with the overflow marker and drops the
// rest of that message up to its flagged last byte.
// The output channel (out_valid/out_ready) returns exactly one item per
// input item: out_status and out_read_byte (the popped byte, else zero).
// out_valid is registered. Unless the receiver stalls, one item is accepted
// every cycle; a single-port byte memory serves either the push write or
// the pop read of that item, and its read data is registered.
// When the receiver stalls, the pending result stays in the output register
// and in_ready drops until it is taken; a new item is accepted in the same
// cycle the pending result leaves.
// The marker is written through cfg_valid/cfg_data, always ready, and
// should only change while the block is idle.
// Reset empties the ring, clears the discard state and loads the marker 'X'.
// No clearing pass over the memory is needed.
module tx_byte_fifo_overflow_marking #(
  parameter int unsigned DEPTH = txbf_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_read_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  import txbf_pkg::*;

  logic       accept;
  logic [7:0] marker_r;
  status_t    ring_status;
  logic [7:0] ring_rd_data;
  logic       out_valid_r;
  status_t    out_status_r;

  // The result register frees up when its item is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_valid) begin
      marker_r <= cfg_data;
    end
  end

  txbf_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (accept),
    .action         (in_action),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .marker         (marker_r),
    .status         (ring_status),
    .rd_data        (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= ring_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  // The memory read register only holds meaning after a successful pop.
  assign out_read_byte = (out_status_r == ST_POPPED) ? ring_rd_data : 8'd0;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import txbf_pkg::*;

  // The block is built with its default ring size; the scoreboard copy of the
  // ring below has the same number of slots.
  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned MAX_GAP = 13;

  typedef struct {
    status_t    status;
    logic [7:0] rbyte;
  } fifo_result_t;

  // All block inputs start at known values; reset is held low from time zero.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = ACT_PUSH;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_read_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // Scoreboard copy of the ring: contents, pointers, the discard flag of an
  // overflowed message and the current marker character.
  logic [7:0]   ring_copy [RING_DEPTH];
  int unsigned  wr_ptr = 0;
  int unsigned  rd_ptr = 0;
  bit           dropping_msg = 1'b0;
  logic [7:0]   marker_copy = MARKER_RESET;

  // Results predicted at input acceptance, oldest first.
  fifo_result_t pending_results[$];

  // When clear, neither the sender nor the receiver inserts idle cycles.
  bit           gaps_on = 1'b1;
  int unsigned  rx_hold = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  marker_writes = 0;
  int unsigned  status_count [5];

  tx_byte_fifo_overflow_marking #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_read_byte    (out_read_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tx_byte_fifo_overflow_marking test failed");
      $finish;
    end
  end

  // Number of bytes the scoreboard ring currently holds.
  function automatic int unsigned ring_level();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  // Applies one accepted item to the scoreboard ring and returns the result the
  // block must produce for it. A push either stores the byte, marks the newest
  // stored byte when the ring is full, or is dropped while the rest of an
  // overflowed message is being thrown away. A pop returns the oldest byte or
  // reports an empty ring.
  function automatic fifo_result_t ring_outcome(logic act, logic [7:0] data_in, logic eom);
    fifo_result_t r;
    r.rbyte = 8'h00;
    if (act == ACT_PUSH) begin
      if (dropping_msg) begin
        r.status = ST_DISCARDED;
        if (eom) dropping_msg = 1'b0;
      end else if ((wr_ptr + 1) % RING_DEPTH == rd_ptr) begin
        ring_copy[(wr_ptr + RING_DEPTH - 1) % RING_DEPTH] = marker_copy;
        r.status = ST_MARKED;
        dropping_msg = !eom;
      end else begin
        ring_copy[wr_ptr] = data_in;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        r.status = ST_STORED;
      end
    end else if (wr_ptr == rd_ptr) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_POPPED;
      r.rbyte = ring_copy[rd_ptr];
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
    end
    return r;
  endfunction

  // Sends one item. The valid line is only lowered when a gap is drawn, so
  // back-to-back items keep it high without a second assignment in one step.
  task automatic send_item(input logic act, input logic [7:0] data_in, input logic eom);
    fifo_result_t r;
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_data_byte <= data_in;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    r = ring_outcome(act, data_in, eom);
    pending_results.push_back(r);
    status_count[int'(r.status)]++;
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back, then
  // idles so the output register settles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the marker register; only called after wait_idle.
  task automatic write_marker(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    marker_copy = value;
    marker_writes++;
  endtask

  // Pushes random bytes until the ring holds its maximum of RING_DEPTH-1.
  // If a message is being discarded, pushes go on until a last byte ends it.
  task automatic fill_ring();
    while (dropping_msg || ring_level() < RING_DEPTH - 1)
      send_item(ACT_PUSH, 8'($urandom), 1'($urandom_range(0, 5) == 0));
  endtask

  // Pops every stored byte, then one pop more to see the empty report.
  task automatic drain_ring();
    while (ring_level() != 0) send_item(ACT_POP, 8'($urandom), 1'($urandom));
    send_item(ACT_POP, 8'($urandom), 1'($urandom));
  endtask

  // Receiver: after each taken result it draws a stall length and holds ready
  // low while that stall counts down.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else if (out_valid && out_ready) begin
      rx_hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      out_ready <= (rx_hold == 0);
    end else if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= (rx_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every taken result is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d read_byte 0x%02h",
                 $time, out_status, out_read_byte);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_status);
          error_count++;
        end
        if (out_read_byte !== want.rbyte) begin
          $display("%0t: read_byte mismatch, expected 0x%02h, actual 0x%02h",
                   $time, want.rbyte, out_read_byte);
          error_count++;
        end
      end
    end
  end

  // Right after reset: a pop on the empty ring, then pushes and pops of the
  // byte extremes and alternating bit patterns, with and without the
  // last-byte flag, ending with another empty pop.
  task automatic test_reset_and_extremes();
    send_item(ACT_POP, 8'hFF, 1'b1);
    send_item(ACT_PUSH, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'hFF, 1'b1);
    send_item(ACT_PUSH, 8'h5A, 1'b0);
    send_item(ACT_PUSH, 8'hA5, 1'b1);
    repeat (4) send_item(ACT_POP, 8'h00, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b0);
    wait_idle();
  endtask

  // Overflow with the reset marker. The ring is filled, then bytes are popped
  // and pushed in pairs until the write pointer sits on slot zero, and the
  // marker must then land on the last slot. Covers a full-ring push that ends
  // its message, one that starts discarding, a discarded push, a pop while
  // discarding, a discarded push into free space and the last byte that ends
  // discarding.
  task automatic test_overflow_and_discard();
    fill_ring();
    while (wr_ptr != 0) begin
      send_item(ACT_POP, 8'h00, 1'b0);
      send_item(ACT_PUSH, 8'($urandom), 1'b0);
    end
    send_item(ACT_PUSH, 8'h11, 1'b1);
    send_item(ACT_PUSH, 8'h22, 1'b0);
    send_item(ACT_PUSH, 8'h33, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'h44, 1'b0);
    send_item(ACT_PUSH, 8'h55, 1'b1);
    send_item(ACT_PUSH, 8'h66, 1'b1);
    drain_ring();
    wait_idle();
  endtask

  // The marker register at both extremes and at a random value: each setting
  // is followed by an overflow and a full drain so the marked byte is read back.
  task automatic test_marker_register();
    logic [7:0] settings [3];
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = 8'($urandom);
    foreach (settings[i]) begin
      write_marker(settings[i]);
      fill_ring();
      send_item(ACT_PUSH, 8'($urandom), 1'b0);
      send_item(ACT_PUSH, 8'($urandom), 1'b1);
      drain_ring();
      wait_idle();
    end
  endtask

  // Random traffic in phases. Each phase leans toward filling, toward draining
  // or stays balanced, so the ring swings between empty and full and messages
  // overflow often. Pushes form messages of random length with the last-byte
  // flag on their final byte; a few pushes carry a random flag instead, which
  // breaks message boundaries. Some phases run without idle cycles, and the
  // marker is rewritten every few phases while the block is idle.
  task automatic test_random_traffic();
    int unsigned start_count;
    int unsigned phase_num;
    int unsigned pop_pct;
    int unsigned phase_len;
    int unsigned msg_left;
    logic        eom;
    start_count = items_sent;
    phase_num = 0;
    msg_left = $urandom_range(1, 24);
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: pop_pct = 15;
        1: pop_pct = 50;
        default: pop_pct = 80;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < pop_pct) begin
          send_item(ACT_POP, 8'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 19) == 0) eom = 1'($urandom);
          else eom = (msg_left == 1);
          send_item(ACT_PUSH, 8'($urandom), eom);
          if (msg_left <= 1) msg_left = $urandom_range(1, 24);
          else msg_left--;
        end
      end
      phase_num++;
      if (phase_num % 4 == 0) begin
        wait_idle();
        write_marker(8'($urandom));
      end
    end
    gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_extremes();
    test_overflow_and_discard();
    test_marker_register();
    test_random_traffic();
    wait_idle();

    $display("Checked %0d stored, %0d marked, %0d discarded, %0d popped, %0d empty results.",
             status_count[ST_STORED], status_count[ST_MARKED], status_count[ST_DISCARDED],
             status_count[ST_POPPED], status_count[ST_EMPTY]);
    $display("Marker register written %0d times; %0d errors found.",
             marker_writes, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tx_byte_fifo_overflow_marking test passed");
    end else begin
      $display("tx_byte_fifo_overflow_marking test failed");
    end
    $finish;
  end

endmodule
